[sv/tick_driven_task_table_scheduler_defines.svh]
// Assertion macros shared by the scheduler's controller and datapath.
// Needs a clock named clock and a synchronous reset named reset in scope.
`ifndef TICK_DRIVEN_TASK_TABLE_SCHEDULER_DEFINES_SVH
`define TICK_DRIVEN_TASK_TABLE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ttts_pkg.sv]
// Shared constants, codes and controller/datapath command types of the scheduler.
// No dependencies.
`timescale 1ns / 1ps

package ttts_pkg;

   localparam int TASK_SLOTS_DEF = 8;
   localparam int RESULT_LIMIT   = 8;
   localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);

   // operation codes of a request word
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DELETE   = 2'd2;
   localparam logic [1:0] OP_DISPATCH = 2'd3;

   // status codes of a response word
   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_RUN   = 3'd3;
   localparam logic [2:0] ST_IDLE  = 3'd4;

   // what the output register loads
   typedef enum logic [2:0] {
      OK_DONE,
      OK_FULL,
      OK_RANGE,
      OK_HELD,
      OK_FLUSH
   } out_kind_type;

   typedef struct packed {
      logic         load;
      logic         rd_en;
      logic         tick_wr;
      logic         add_wr;
      logic         del_clr;
      logic         disp_wr;
      logic         hold_load;
      logic         out_load;
      out_kind_type out_kind;
      logic [3:0]   out_slot;
   } ttts_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic slot_ready;
      logic hold_valid;
      logic out_free;
      logic idx_ok;
   } ttts_stat_type;

endpackage

[sv/ttts_req_if.sv]
// Request channel of the scheduler: valid/ready handshake and one request word.
// No dependencies.
`timescale 1ns / 1ps

interface ttts_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] first_delay;
   logic [15:0] repeat_period;
   logic [15:0] task_tag;
   logic [7:0]  slot_index;

   modport source (output valid, op, first_delay, repeat_period, task_tag, slot_index,
                   input ready);
   modport sink   (input valid, op, first_delay, repeat_period, task_tag, slot_index,
                   output ready);
endinterface

[sv/ttts_rsp_if.sv]
// Response channel of the scheduler: valid/ready handshake and one response word.
// No dependencies.
`timescale 1ns / 1ps

interface ttts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  slot;
   logic [15:0] tag_out;
   logic        last;

   modport source (output valid, status, slot, tag_out, last, input ready);
   modport sink   (input valid, status, slot, tag_out, last, output ready);
endinterface

[sv/ttts_ctrl.sv]
// Scheduler controller: state machine that walks the slot table and drives the datapath.
// Depends on ttts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tick_driven_task_table_scheduler_defines.svh"

module ttts_ctrl #(
   parameter int  TASK_SLOTS = ttts_pkg::TASK_SLOTS_DEF,
   localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_op,
   output logic                     req_ready,
   input  ttts_pkg::ttts_stat_type  stat,
   output ttts_pkg::ttts_cmd_type   cmd,
   output logic [IDX_W-1:0]         cur_idx,
   output logic [IDX_W-1:0]         rd_addr
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_ADD,
      S_DEL,
      S_DISP,
      S_RESP
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [ttts_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   ttts_pkg::out_kind_type       kind_ff, kind_in;
   logic [3:0]                   rslot_ff, rslot_in;

   logic                         last_idx;
   logic [IDX_W-1:0]             next_idx;
   logic [ttts_pkg::CNT_W-1:0]   cnt_inc;

   assign last_idx = (idx_ff == IDX_W'(TASK_SLOTS - 1));
   assign next_idx = idx_ff + IDX_W'(1);
   assign cnt_inc  = cnt_ff + ttts_pkg::CNT_W'(1);
   assign cur_idx  = idx_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      rslot_in  = rslot_ff;
      req_ready = 1'b0;
      rd_addr   = '0;
      cmd       = '0;
      cmd.out_kind = kind_ff;
      cmd.out_slot = rslot_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               cnt_in   = '0;
               rslot_in = '0;
               unique case (req_op)
                  ttts_pkg::OP_TICK: begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_TICK;
                  end
                  ttts_pkg::OP_ADD:    state_in = S_ADD;
                  ttts_pkg::OP_DELETE: state_in = S_DEL;
                  default: begin
                     cmd.rd_en = 1'b1;
                     state_in  = S_DISP;
                  end
               endcase
            end
         end
         S_TICK: begin
            cmd.tick_wr = 1'b1;
            if (last_idx) begin
               kind_in  = ttts_pkg::OK_DONE;
               state_in = S_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = next_idx;
               idx_in    = next_idx;
            end
         end
         S_ADD: begin
            priority if (stat.slot_free) begin
               cmd.add_wr = 1'b1;
               kind_in    = ttts_pkg::OK_DONE;
               rslot_in   = 4'(idx_ff);
               state_in   = S_RESP;
            end else if (last_idx) begin
               kind_in  = ttts_pkg::OK_FULL;
               state_in = S_RESP;
            end else begin
               idx_in = next_idx;
            end
         end
         S_DEL: begin
            cmd.del_clr = 1'b1;
            kind_in     = stat.idx_ok ? ttts_pkg::OK_DONE : ttts_pkg::OK_RANGE;
            state_in    = S_RESP;
         end
         S_DISP: begin
            priority if (stat.slot_ready) begin
               // a second run waits until the held word can move out
               if (!stat.hold_valid || stat.out_free) begin
                  cmd.disp_wr   = 1'b1;
                  cmd.hold_load = 1'b1;
                  cmd.out_load  = stat.hold_valid;
                  cmd.out_kind  = ttts_pkg::OK_HELD;
                  cnt_in        = cnt_inc;
                  if (last_idx || cnt_inc == ttts_pkg::CNT_W'(ttts_pkg::RESULT_LIMIT)) begin
                     kind_in  = ttts_pkg::OK_FLUSH;
                     state_in = S_RESP;
                  end else begin
                     cmd.rd_en = 1'b1;
                     rd_addr   = next_idx;
                     idx_in    = next_idx;
                  end
               end
            end else if (last_idx) begin
               kind_in  = ttts_pkg::OK_FLUSH;
               state_in = S_RESP;
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = next_idx;
               idx_in    = next_idx;
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         kind_ff  <= ttts_pkg::OK_DONE;
         rslot_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         kind_ff  <= kind_in;
         rslot_ff <= rslot_in;
      end
   end

   `TTTS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_ff <= ttts_pkg::CNT_W'(ttts_pkg::RESULT_LIMIT), "dispatch count past limit")
   `TTTS_ASSERT_NEXT(a_resp_done, state_ff == S_RESP && stat.out_free, state_ff == S_IDLE, "response did not retire")
   `TTTS_ASSERT_NOW(a_ready_idle, req_ready, state_ff == S_IDLE, "request taken outside idle")

endmodule

[sv/ttts_datapath.sv]
// Scheduler datapath: slot table memory, valid bits, held dispatch word and output register.
// Depends on ttts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "tick_driven_task_table_scheduler_defines.svh"

module ttts_datapath #(
   parameter int  TASK_SLOTS = ttts_pkg::TASK_SLOTS_DEF,
   localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ttts_pkg::ttts_cmd_type   cmd,
   output ttts_pkg::ttts_stat_type  stat,
   input  logic [IDX_W-1:0]         cur_idx,
   input  logic [IDX_W-1:0]         rd_addr,
   input  logic [15:0]              req_first_delay,
   input  logic [15:0]              req_repeat_period,
   input  logic [15:0]              req_task_tag,
   input  logic [7:0]               req_slot_index,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_status,
   output logic [3:0]               rsp_slot,
   output logic [15:0]              rsp_tag_out,
   output logic                     rsp_last
);

   typedef struct packed {
      logic [15:0] delay;
      logic [15:0] period;
      logic [7:0]  runs;
      logic [15:0] tag;
   } entry_type;

   // latched request word
   logic [15:0]       delay_ff, period_ff, tag_ff;
   logic [7:0]        sidx_ff;

   entry_type         tbl_ff [TASK_SLOTS];
   entry_type         rd_ff;
   entry_type         tick_data, wr_data;
   logic              wr_en;

   logic [TASK_SLOTS-1:0] vld_ff, vld_in;

   logic              hold_valid_ff, hold_valid_in;
   logic [3:0]        hold_slot_ff;
   logic [15:0]       hold_tag_ff;

   logic              out_valid_ff, out_valid_in;
   logic [2:0]        out_status_ff, out_status_in;
   logic [3:0]        out_slot_ff, out_slot_in;
   logic [15:0]       out_tag_ff, out_tag_in;
   logic              out_last_ff, out_last_in;

   logic              idx_ok;

   assign idx_ok = (sidx_ff < 8'(TASK_SLOTS));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         delay_ff  <= req_first_delay;
         period_ff <= req_repeat_period;
         tag_ff    <= req_task_tag;
         sidx_ff   <= req_slot_index;
      end
   end

   // tick: at zero count a run and reload from a nonzero period, else count down
   always_comb begin
      tick_data = rd_ff;
      if (rd_ff.delay == 16'd0) begin
         if (rd_ff.runs != 8'hFF) tick_data.runs = rd_ff.runs + 8'd1;
         if (rd_ff.period != 16'd0) tick_data.delay = rd_ff.period;
      end else begin
         tick_data.delay = rd_ff.delay - 16'd1;
      end
   end

   always_comb begin
      wr_en   = cmd.add_wr | cmd.disp_wr | (cmd.tick_wr & vld_ff[cur_idx]);
      wr_data = tick_data;
      priority if (cmd.add_wr) begin
         wr_data = '{delay: delay_ff, period: period_ff, runs: 8'd0, tag: tag_ff};
      end else if (cmd.disp_wr) begin
         wr_data      = rd_ff;
         wr_data.runs = rd_ff.runs - 8'd1;
      end else begin
         wr_data = tick_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) tbl_ff[cur_idx] <= wr_data;
      if (cmd.rd_en) rd_ff <= tbl_ff[rd_addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.add_wr) vld_in[cur_idx] = 1'b1;
      if (cmd.disp_wr && rd_ff.period == 16'd0) vld_in[cur_idx] = 1'b0;
      if (cmd.del_clr && idx_ok) vld_in[sidx_ff[IDX_W-1:0]] = 1'b0;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (cmd.hold_load) begin
         hold_valid_in = 1'b1;
      end else if (cmd.out_load && cmd.out_kind == ttts_pkg::OK_FLUSH) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff & ~rsp_ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         out_slot_in  = 4'd0;
         out_tag_in   = 16'd0;
         out_last_in  = 1'b1;
         unique case (cmd.out_kind)
            ttts_pkg::OK_DONE: begin
               out_status_in = ttts_pkg::ST_DONE;
               out_slot_in   = cmd.out_slot;
            end
            ttts_pkg::OK_FULL: begin
               out_status_in = ttts_pkg::ST_FULL;
               out_slot_in   = 4'(TASK_SLOTS);
            end
            ttts_pkg::OK_RANGE: out_status_in = ttts_pkg::ST_RANGE;
            ttts_pkg::OK_HELD: begin
               out_status_in = ttts_pkg::ST_RUN;
               out_slot_in   = hold_slot_ff;
               out_tag_in    = hold_tag_ff;
               out_last_in   = 1'b0;
            end
            default: begin
               if (hold_valid_ff) begin
                  out_status_in = ttts_pkg::ST_RUN;
                  out_slot_in   = hold_slot_ff;
                  out_tag_in    = hold_tag_ff;
               end else begin
                  out_status_in = ttts_pkg::ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         vld_ff        <= vld_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      if (cmd.hold_load) begin
         hold_slot_ff <= 4'(cur_idx);
         hold_tag_ff  <= rd_ff.tag;
      end
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   assign stat.slot_free  = ~vld_ff[cur_idx];
   assign stat.slot_ready = vld_ff[cur_idx] & (rd_ff.runs != 8'd0);
   assign stat.hold_valid = hold_valid_ff;
   assign stat.out_free   = ~out_valid_ff | rsp_ready;
   assign stat.idx_ok     = idx_ok;

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_slot    = out_slot_ff;
   assign rsp_tag_out = out_tag_ff;
   assign rsp_last    = out_last_ff;

   `TTTS_ASSERT_NOW(a_out_room, cmd.out_load, ~out_valid_ff | rsp_ready, "output overwritten")
   `TTTS_ASSERT_NOW(a_hold_spill, cmd.hold_load && hold_valid_ff, cmd.out_load, "held run lost")
   `TTTS_ASSERT_NOW(a_add_free, cmd.add_wr, ~vld_ff[cur_idx], "add into a live slot")

endmodule

[sv/tick_driven_task_table_scheduler.sv]
// Channel     Dir  Handshake    Word
// req_ch      in   valid/ready  op, first_delay, repeat_period, task_tag, slot_index
// rsp_ch      out  valid/ready  status, slot, tag_out, last
//
// One request at a time. A tick walks the slot table one slot per cycle through the
// single-read-port table memory; a dispatch does so too while it does not stall.
// Add scans valid bits for the first free slot; delete clears the named slot's valid bit.
// Dispatch stalls while a run word is waiting and the output register is still full;
// every request also holds its final word until the output register frees up.
// Synchronous reset empties the table (valid bits only) and drops pending words.
//
// Top level of the tick-driven task table scheduler; joins controller and datapath.
// Depends on ttts_pkg, ttts_req_if, ttts_rsp_if, ttts_ctrl and ttts_datapath.
`timescale 1ns / 1ps

module tick_driven_task_table_scheduler #(
   parameter int TASK_SLOTS = ttts_pkg::TASK_SLOTS_DEF
) (
   input logic         clock,
   input logic         reset,
   ttts_req_if.sink    req_ch,
   ttts_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   ttts_pkg::ttts_cmd_type  cmd;
   ttts_pkg::ttts_stat_type stat;
   logic [IDX_W-1:0]        cur_idx;
   logic [IDX_W-1:0]        rd_addr;
   logic                    req_ready;

   // controller: sequence the request, walk slot indexes, gate output loads
   ttts_ctrl #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd),
      .cur_idx   (cur_idx),
      .rd_addr   (rd_addr)
   );

   // datapath: hold the slot table, update slots, build response words
   ttts_datapath #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .cur_idx           (cur_idx),
      .rd_addr           (rd_addr),
      .req_first_delay   (req_ch.first_delay),
      .req_repeat_period (req_ch.repeat_period),
      .req_task_tag      (req_ch.task_tag),
      .req_slot_index    (req_ch.slot_index),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_slot          (rsp_ch.slot),
      .rsp_tag_out       (rsp_ch.tag_out),
      .rsp_last          (rsp_ch.last)
   );

   // take a new request only from the idle state
   assign req_ch.ready = req_ready;

endmodule
